/* design/sss_pkg.sv */
// shared types and constants for the subset-sum backtracking search block
// no dependencies; imported by the step unit, the top module and the testbench
package sss_pkg;

    localparam int MAX_ELEMENTS_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int TARGET_W         = 21;
    localparam int WEIGHT_IN_W      = 16;
    localparam int MASK_W           = 32;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_FIND = 1'b1
    } op_t;

    typedef enum logic {
        STEP_DESCEND = 1'b0,
        STEP_RETREAT = 1'b1
    } step_mode_t;

    // compare results of one evaluation by the step unit
    typedef struct packed {
        logic short_fall;   // running + remaining below target
        logic at_target;    // running weight equals target
        logic fits;         // running + next weight does not overshoot
    } step_flags_t;

endpackage

/* design/sss_ram.sv */
// generic single-write, single-read memory with registered read data
// depends on nothing; used for the weight store
module sss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/sss_step.sv */
// shared add/subtract and compare unit of the search sequencer
// depends on sss_pkg
module sss_step
    import sss_pkg::*;
#(
    parameter int EW    = 16,
    parameter int SUM_W = 22
) (
    input  step_mode_t            mode,
    input  logic [SUM_W-1:0]      rw,
    input  logic [SUM_W-1:0]      rem,
    input  logic [EW-1:0]         w,
    input  logic [TARGET_W-1:0]   target,
    output step_flags_t           flags,
    output logic [SUM_W-1:0]      rw_new,
    output logic [SUM_W-1:0]      rem_new
);

    localparam int CW = ((SUM_W > TARGET_W) ? SUM_W : TARGET_W) + 1;

    logic [CW-1:0]    rw_x, rem_x, w_x, tgt_x, rr_sum, rw_plus;
    logic [SUM_W-1:0] w_s;

    assign rw_x   = CW'(rw);
    assign rem_x  = CW'(rem);
    assign w_x    = CW'(w);
    assign tgt_x  = CW'(target);
    assign w_s    = SUM_W'(w);
    assign rr_sum = rw_x + rem_x;
    assign rw_plus = rw_x + w_x;

    assign flags.short_fall = rr_sum < tgt_x;
    assign flags.at_target  = rw_x == tgt_x;
    assign flags.fits       = rw_plus <= tgt_x;

    // descend: take the element; retreat: give it back or return it to the pool
    assign rw_new  = (mode == STEP_RETREAT) ? (rw - w_s) : rw_plus[SUM_W-1:0];
    assign rem_new = (mode == STEP_RETREAT) ? (rem + w_s) : (rem - w_s);

endmodule

/* design/subset_sum_backtrack_search_top.sv */
// subset-sum backtracking search: a load is accepted in the idle state; a find request walks the tree
// one node test or retreat step at a time (weight memory read, then step unit) and then
// presents the result; the total time is data dependent
// one item at a time: s_ready is low from a find transfer until its result is taken
// reset: aresetn synchronous active low clears set size, total, target, search phase and
// the output valid; the weight memory is not cleared (only loaded entries are ever used)
module subset_sum_backtrack_search_top
    import sss_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // target register write
    input  logic                   cfg_we,
    input  logic [TARGET_W-1:0]    cfg_wdata,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    input  logic                   s_first,
    input  logic [WEIGHT_IN_W-1:0] s_weight_value,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [MASK_W-1:0]      m_include_mask,
    output logic                   m_found
);

    // effective weight width, level/count width, memory address width, sum width
    localparam int EW    = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
    localparam int LW    = $clog2(MAX_ELEMENTS + 1);
    localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SUM_W = EW + LW;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,   // waiting for a transfer
        S_FETCH  = 6'b000010,   // read weight of next element
        S_EVAL   = 6'b000100,   // node test, descend or give up
        S_BFETCH = 6'b001000,   // read weight of current level for backtrack
        S_BACK   = 6'b010000,   // flip include to exclude or pop a level
        S_OUT    = 6'b100000    // result held until taken
    } state_t;

    // search progress between requests
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,       // restart from empty path on next request
        PH_ACTIVE = 2'd1,       // resume after last solution
        PH_DONE   = 2'd2        // tree exhausted
    } phase_t;

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [TARGET_W-1:0]   target_reg, target_next;
    logic [LW-1:0]         cnt_reg, cnt_next;
    logic [SUM_W-1:0]      total_reg, total_next;
    logic [MAX_ELEMENTS-1:0] bits_reg, bits_next;
    logic [LW-1:0]         lvl_reg, lvl_next;      // level index plus one
    logic [SUM_W-1:0]      rw_reg, rw_next;
    logic [SUM_W-1:0]      rem_reg, rem_next;
    logic                  m_valid_reg, m_valid_next;
    logic [MASK_W-1:0]     m_mask_reg, m_mask_next;
    logic                  m_found_reg, m_found_next;

    logic                  s_xfer;
    logic                  load_we;
    logic [AW-1:0]         load_addr;
    logic [EW-1:0]         load_w;
    logic [AW-1:0]         rd_addr;
    logic [EW-1:0]         rd_w;
    logic [LW-1:0]         lvl_dec;
    logic                  has_room;
    step_mode_t            step_mode;
    step_flags_t           step_flags;
    logic [SUM_W-1:0]      step_rw, step_rem;
    logic [MASK_W-1:0]     mask_view;

    assign s_ready        = (state_reg == S_IDLE);
    assign s_xfer         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_include_mask = m_mask_reg;
    assign m_found        = m_found_reg;

    assign lvl_dec  = lvl_reg - LW'(1);
    assign has_room = cnt_reg < LW'(MAX_ELEMENTS);
    assign load_w   = s_weight_value[EW-1:0];

    // a first flag always lands at entry zero; otherwise append while room is left
    assign load_we   = s_xfer && (s_op == OP_LOAD) && (s_first || has_room);
    assign load_addr = s_first ? '0 : cnt_reg[AW-1:0];

    // next element on a forward step, current level on a backtrack step
    assign rd_addr = (state_reg == S_BFETCH) ? lvl_dec[AW-1:0] : lvl_reg[AW-1:0];

    sss_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_weights (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (load_w),
        .raddr (rd_addr),
        .rdata (rd_w)
    );

    assign step_mode = (state_reg == S_BACK) ? STEP_RETREAT : STEP_DESCEND;

    sss_step #(
        .EW    (EW),
        .SUM_W (SUM_W)
    ) u_step (
        .mode    (step_mode),
        .rw      (rw_reg),
        .rem     (rem_reg),
        .w       (rd_w),
        .target  (target_reg),
        .flags   (step_flags),
        .rw_new  (step_rw),
        .rem_new (step_rem)
    );

    // result shows only the low element bits
    generate
        if (MAX_ELEMENTS >= MASK_W) begin : g_mask_cut
            assign mask_view = bits_reg[MASK_W-1:0];
        end else begin : g_mask_ext
            assign mask_view = MASK_W'(bits_reg);
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        target_next  = target_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        bits_next    = bits_reg;
        lvl_next     = lvl_reg;
        rw_next      = rw_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg;
        m_mask_next  = m_mask_reg;
        m_found_next = m_found_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    if (s_op == OP_LOAD) begin
                        // any load restarts the search
                        phase_next = PH_IDLE;
                        if (s_first) begin
                            cnt_next   = LW'(1);
                            total_next = SUM_W'(load_w);
                        end else if (has_room) begin
                            cnt_next   = cnt_reg + LW'(1);
                            total_next = total_reg + SUM_W'(load_w);
                        end
                    end else begin
                        case (phase_reg)
                            PH_IDLE: begin
                                // empty path, all weights still available
                                bits_next  = '0;
                                lvl_next   = '0;
                                rw_next    = '0;
                                rem_next   = total_reg;
                                state_next = S_FETCH;
                            end
                            PH_ACTIVE: begin
                                // leave the last solution by backtracking
                                state_next = S_BFETCH;
                            end
                            default: begin
                                // exhausted search keeps answering not found
                                m_valid_next = 1'b1;
                                m_mask_next  = '0;
                                m_found_next = 1'b0;
                                state_next   = S_OUT;
                            end
                        endcase
                    end
                end
            end
            S_FETCH: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (step_flags.short_fall) begin
                    state_next = S_BFETCH;
                end else if (step_flags.at_target) begin
                    // solution: report, do not descend
                    phase_next   = PH_ACTIVE;
                    m_valid_next = 1'b1;
                    m_mask_next  = mask_view;
                    m_found_next = 1'b1;
                    state_next   = S_OUT;
                end else if ((lvl_reg < cnt_reg) && step_flags.fits) begin
                    // include the next element first
                    bits_next[lvl_reg[AW-1:0]] = 1'b1;
                    rw_next    = step_rw;
                    rem_next   = step_rem;
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = S_FETCH;
                end else begin
                    state_next = S_BFETCH;
                end
            end
            S_BFETCH: begin
                if (lvl_reg == '0) begin
                    // above the first element: tree exhausted
                    phase_next   = PH_DONE;
                    m_valid_next = 1'b1;
                    m_mask_next  = '0;
                    m_found_next = 1'b0;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_BACK;
                end
            end
            S_BACK: begin
                if (bits_reg[lvl_dec[AW-1:0]]) begin
                    // include branch done, try exclude at same level
                    bits_next[lvl_dec[AW-1:0]] = 1'b0;
                    rw_next    = step_rw;
                    state_next = S_FETCH;
                end else begin
                    // both branches done, pop the level
                    rem_next   = step_rem;
                    lvl_next   = lvl_dec;
                    state_next = S_BFETCH;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // target write restarts the search; the user must write it only while idle, the block does not enforce this
        if (cfg_we) begin
            target_next = cfg_wdata;
            phase_next  = PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_IDLE;
            target_reg  <= '0;
            cnt_reg     <= '0;
            total_reg   <= '0;
            bits_reg    <= '0;
            lvl_reg     <= '0;
            rw_reg      <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            target_reg  <= target_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            bits_reg    <= bits_next;
            lvl_reg     <= lvl_next;
            rw_reg      <= rw_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_mask_reg  <= m_mask_next;
        m_found_reg <= m_found_next;
    end

    // one item in flight: never ready while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while result pending");

    // a not-found result carries an empty mask
    a_empty_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_include_mask == '0))
        else $error("mask set on not-found result");

    // result transfer frees the block
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready)
        else $error("not ready after result transfer");

    // the overshoot pruning keeps the running weight at or below the target
    a_no_overshoot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (SUM_W'(rw_reg) <= SUM_W'(target_reg) ||
                                   SUM_W < TARGET_W))
        else $error("running weight above target");

    // set size never passes the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LW'(MAX_ELEMENTS))
        else $error("element count out of range");

endmodule

/* tb/solution_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// scoreboard for the subset-sum backtracking search block: search predictor and result check
// depends on sss_pkg for the op codes and field widths
package solution_scoreboard_pkg;
    import sss_pkg::*;

    typedef struct {
        bit [MASK_W-1:0] include_mask;
        bit              found;
    } solution_t;

    typedef enum int {
        SEARCH_FRESH,
        SEARCH_RESUMABLE,
        SEARCH_EXHAUSTED
    } search_state_t;

    class solution_scoreboard;
        bit [WEIGHT_IN_W-1:0]      weights [MAX_ELEMENTS_DEF];
        int unsigned               set_size;
        int unsigned               set_total;
        bit [MAX_ELEMENTS_DEF-1:0] path_bits;
        int                        depth;
        int unsigned               path_weight;
        int unsigned               weight_left;
        int unsigned               target;
        search_state_t             state;
        int unsigned               tree_steps;
        int unsigned               step_cap;     // nonzero only for cost estimates
        int unsigned               mismatches;
        solution_t                 expected_solutions [$];

        function new();
            set_size    = 0;
            set_total   = 0;
            path_bits   = '0;
            depth       = -1;
            path_weight = 0;
            weight_left = 0;
            target      = 0;
            state       = SEARCH_FRESH;
            tree_steps  = 0;
            step_cap    = 0;
            mismatches  = 0;
        endfunction

        function void set_target(int unsigned value);
            target = value & ((1 << TARGET_W) - 1);
            state  = SEARCH_FRESH;
        endfunction

        // worth descending: enough weight left, and at the target or the next one fits
        function bit node_viable();
            int nxt;
            nxt = depth + 1;
            if (path_weight + weight_left < target) return 1'b0;
            if (path_weight == target) return 1'b1;
            if (nxt >= int'(set_size)) return 1'b0;
            return path_weight + weights[nxt] <= target;
        endfunction

        // move to the exclude branch of the deepest included element
        function bit backtrack();
            while (depth >= 0) begin
                tree_steps++;
                if (path_bits[depth]) begin
                    path_bits[depth] = 1'b0;
                    path_weight -= weights[depth];
                    return 1'b1;
                end
                weight_left += weights[depth];
                depth--;
            end
            return 1'b0;
        endfunction

        function bit search_forward();
            bit done;
            bit hit;
            done = 1'b0;
            hit  = 1'b0;
            while (!done) begin
                tree_steps++;
                if (step_cap != 0 && tree_steps > step_cap) begin
                    done = 1'b1;
                end else if (node_viable()) begin
                    if (path_weight == target) begin
                        hit  = 1'b1;
                        done = 1'b1;
                    end else begin
                        depth++;
                        path_bits[depth] = 1'b1;
                        path_weight += weights[depth];
                        weight_left -= weights[depth];
                    end
                end else if (!backtrack()) begin
                    done = 1'b1;
                end
            end
            return hit;
        endfunction

        // one accepted request: loads update the set, finds queue the next solution
        function void note_request(op_t op, bit first, bit [WEIGHT_IN_W-1:0] weight);
            bit        hit;
            solution_t next;
            if (op == OP_LOAD) begin
                if (first) begin
                    set_size  = 0;
                    set_total = 0;
                end
                if (set_size < MAX_ELEMENTS_DEF) begin
                    weights[set_size] = weight;
                    set_size++;
                    set_total += weight;
                end
                state = SEARCH_FRESH;
                return;
            end
            hit = 1'b0;
            if (state == SEARCH_FRESH) begin
                path_bits   = '0;
                depth       = -1;
                path_weight = 0;
                weight_left = set_total;
                hit = search_forward();
            end else if (state == SEARCH_RESUMABLE) begin
                if (backtrack()) hit = search_forward();
            end
            state = hit ? SEARCH_RESUMABLE : SEARCH_EXHAUSTED;
            next.include_mask = hit ? path_bits[MASK_W-1:0] : '0;
            next.found        = hit;
            expected_solutions.push_back(next);
        endfunction

        function void check_solution(logic [MASK_W-1:0] include_mask, logic found);
            solution_t want;
            if (expected_solutions.size() == 0) begin
                $display("%0t: unexpected result, include_mask %h found %b",
                         $time, include_mask, found);
                mismatches++;
                return;
            end
            want = expected_solutions.pop_front();
            if (include_mask !== want.include_mask) begin
                $display("%0t: include_mask expected %h actual %h",
                         $time, want.include_mask, include_mask);
                mismatches++;
            end
            if (found !== want.found) begin
                $display("%0t: found expected %b actual %b", $time, want.found, found);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_solutions.size();
        endfunction
    endclass

endpackage

/* tb/tb_subset_sum_backtrack_search_top.sv */
`timescale 1ns / 100ps
// top-level testbench for the subset-sum backtracking search block
// drives loads, find requests and target writes; needs sss_pkg and solution_scoreboard_pkg
module tb_subset_sum_backtrack_search_top;
    import sss_pkg::*;
    import solution_scoreboard_pkg::*;

    localparam int unsigned TARGET_TOP   = (1 << TARGET_W) - 1;       // all target bits set
    localparam int unsigned WEIGHT_TOP   = (1 << WEIGHT_IN_W) - 1;
    localparam int unsigned FULL_SET_SUM = MAX_ELEMENTS_DEF * WEIGHT_TOP;
    localparam int          ITEM_GOAL    = 1750;
    localparam int unsigned STEP_BUDGET  = 1000;   // tree steps allowed per set of finds
    localparam int          HOLD_CYCLES  = 3000;   // outlasts the longest first search of a set
    localparam int          LOAD_SETTLE  = 4;      // a load leaves the block ready and gives no result
    localparam int          END_SETTLE   = 20;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [TARGET_W-1:0]    cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_op;
    logic                   s_first;
    logic [WEIGHT_IN_W-1:0] s_weight_value;
    logic                   m_valid;
    logic                   m_ready;
    logic [MASK_W-1:0]      m_include_mask;
    logic                   m_found;

    solution_scoreboard sb;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    bit                 hold_req;
    int                 items_sent;

    subset_sum_backtrack_search_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_first        (s_first),
        .s_weight_value (s_weight_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_include_mask (m_include_mask),
        .m_found        (m_found)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit: well above the slowest legal run
    initial begin
        #(30_000_000);
        $display("FAIL subset_sum_backtrack_search_top");
        $finish;
    end

    // result side ready: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // every result transfer is checked against the oldest predicted solution
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_solution(m_include_mask, m_found);
    end

    // one request transfer; valid stays up between back-to-back items
    task automatic send_item(op_t op, bit first, bit [WEIGHT_IN_W-1:0] weight);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_first        <= first;
        s_weight_value <= weight;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(op, first, weight);
        items_sent++;
    endtask

    // sender pauses until every outstanding result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LOAD_SETTLE) @(posedge aclk);
    endtask

    // only called with the block idle
    task automatic write_target(int unsigned value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[TARGET_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_target(value);
        @(posedge aclk);
    endtask

    initial begin
        int                     n;
        int                     nf;
        int                     restart_at;
        int unsigned            span;
        int unsigned            cand;
        int unsigned            tgt;
        int unsigned            pick;
        bit                     append;
        bit                     hold_now;
        bit [WEIGHT_IN_W-1:0]   set_weights [$];
        solution_scoreboard     probe;

        sb             = new();
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_op           = OP_LOAD;
        s_first        = 1'b0;
        s_weight_value = '0;
        hold_req       = 1'b0;
        items_sent     = 0;
        send_idle_pct  = 28;
        recv_idle_pct  = 85;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // ---------------- directed part ----------------
        // empty set with the reset target of zero: empty subset once, then exhausted
        send_item(OP_FIND, 1'b1, WEIGHT_IN_W'(WEIGHT_TOP));
        send_item(OP_FIND, 1'b0, 16'd0);
        send_item(OP_FIND, 1'b0, 16'd0);   // exhausted answer repeats

        // duplicate zero weights and the largest weight
        send_item(OP_LOAD, 1'b1, 16'd0);
        send_item(OP_LOAD, 1'b0, 16'd0);
        send_item(OP_LOAD, 1'b0, WEIGHT_IN_W'(WEIGHT_TOP));
        send_item(OP_FIND, 1'b0, 16'd0);
        send_item(OP_FIND, 1'b1, 16'd0);

        // zero weights make several masks reach the same sum
        drain_results();
        write_target(WEIGHT_TOP);
        repeat (5) send_item(OP_FIND, 1'($urandom_range(1)),
                             WEIGHT_IN_W'($urandom_range(WEIGHT_TOP)));

        // same target rewritten: search restarts from the empty path
        drain_results();
        write_target(WEIGHT_TOP);
        send_item(OP_FIND, 1'b0, 16'd0);
        // an appended load restarts it as well, this one out of order
        send_item(OP_LOAD, 1'b0, 16'd1);
        send_item(OP_FIND, 1'b0, 16'd0);

        // target beyond any reachable sum
        drain_results();
        write_target(TARGET_TOP);
        send_item(OP_FIND, 1'b0, 16'd0);

        // unsorted set, solutions found in load order
        send_item(OP_LOAD, 1'b1, 16'd7);
        send_item(OP_LOAD, 1'b0, 16'd3);
        send_item(OP_LOAD, 1'b0, 16'd4);
        drain_results();
        write_target(7);
        repeat (3) send_item(OP_FIND, 1'b0, 16'd0);

        // full store of maximum weights, one extra load is dropped
        drain_results();
        write_target(FULL_SET_SUM);
        for (int i = 0; i <= MAX_ELEMENTS_DEF; i++)
            send_item(OP_LOAD, i == 0, WEIGHT_IN_W'(WEIGHT_TOP));
        repeat (2) send_item(OP_FIND, 1'b0, 16'd0);

        // ---------------- random sets ----------------
        while (items_sent < ITEM_GOAL) begin
            hold_now = 1'b0;
            if (items_sent < ITEM_GOAL / 3) begin
                send_idle_pct = 28;
                recv_idle_pct = 85;
            end else if (items_sent < 2 * ITEM_GOAL / 3) begin
                send_idle_pct = 85;
                recv_idle_pct = 28;
            end else begin
                // first set of the last third: long receiver hold-off
                hold_now = (send_idle_pct != 0);
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // set size: mostly small, a few overflow the store
            pick = $urandom_range(99);
            if (pick < 80)      n = $urandom_range(1, 10);
            else if (pick < 92) n = $urandom_range(11, 20);
            else                n = $urandom_range(MAX_ELEMENTS_DEF, MAX_ELEMENTS_DEF + 4);
            case ($urandom_range(2))
                0:       span = 15;
                1:       span = 255;
                default: span = WEIGHT_TOP;
            endcase
            set_weights.delete();
            repeat (n) set_weights.push_back(WEIGHT_IN_W'($urandom_range(span)));
            if ($urandom_range(9) != 0) set_weights.sort();   // else left unsorted
            append = (sb.set_size != 0) && ($urandom_range(6) == 0);
            // during the hold-off a second find queues up behind the held result
            nf     = hold_now ? $urandom_range(2, 12) : $urandom_range(1, 12);

            // pick a target whose search stays within the step budget
            tgt = 0;
            for (int t = 0; t < 6; t++) begin
                probe = new();
                probe.step_cap = STEP_BUDGET;
                if (append) begin
                    probe.weights   = sb.weights;
                    probe.set_size  = sb.set_size;
                    probe.set_total = sb.set_total;
                end
                foreach (set_weights[i])
                    probe.note_request(OP_LOAD, (i == 0) && !append, set_weights[i]);
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        // sum of a random subset, so a solution exists
                        pick = $urandom;
                        cand = 0;
                        for (int k = 0; k < int'(probe.set_size); k++)
                            if (pick[k]) cand += probe.weights[k];
                    end
                    4:       cand = $urandom_range(probe.set_total);
                    5:       cand = 0;
                    6:       cand = probe.set_total;
                    7:       cand = $urandom_range(TARGET_TOP);
                    8:       cand = TARGET_TOP;
                    default: cand = probe.set_total + $urandom_range(1, 40);
                endcase
                if (cand > TARGET_TOP) cand = TARGET_TOP;
                probe.set_target(cand);
                repeat (nf) probe.note_request(OP_FIND, 1'b0, 16'd0);
                if (probe.tree_steps <= STEP_BUDGET) begin
                    tgt = cand;
                    break;
                end
            end

            drain_results();
            write_target(tgt);
            // receiver holds off while this set's loads and finds are offered
            if (hold_now) hold_req = 1'b1;
            foreach (set_weights[i])
                send_item(OP_LOAD, (i == 0) && !append, set_weights[i]);
            restart_at = ($urandom_range(9) == 0) ? $urandom_range(1, nf) : -1;
            for (int f = 0; f < nf; f++) begin
                if (f == restart_at) begin
                    // same target again throws away the search position
                    drain_results();
                    write_target(tgt);
                end
                // first and weight carry random don't-care values on finds
                send_item(OP_FIND, 1'($urandom_range(1)),
                          WEIGHT_IN_W'($urandom_range(WEIGHT_TOP)));
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("PASS subset_sum_backtrack_search_top");
        end else begin
            $display("FAIL subset_sum_backtrack_search_top");
        end
        $finish;
    end

endmodule
